### rtl/core/dlbd_pkg.sv
// Shared types, constants and helpers for the definite-length block deframer.
// No dependencies; every other file of the block refers to this package.
package dlbd_pkg;

  localparam int unsigned MAX_LEN_DIGITS = 15;

  // field and register widths
  localparam int unsigned LEN_W      = 50;
  localparam int unsigned RL_W       = 24;
  localparam int unsigned BPP_W      = 2;
  localparam int unsigned FC_W       = 16;
  localparam int unsigned RB_W       = RL_W + BPP_W;
  localparam int unsigned EXP_W      = RB_W + FC_W;
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_FRAME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUMMARY_FRAME = 3'd4;

  // request modes
  localparam logic [1:0] MODE_STREAM = 2'd0;
  localparam logic [1:0] MODE_ARM    = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;

  // parser phases
  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_COUNT   = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [7:0] CHAR_HASH = 8'h23;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic [RL_W-1:0]  record_length;
    logic [BPP_W-1:0] bytes_per_point;
    logic [FC_W-1:0]  frame_count;
    logic             fast_frame_enable;
    logic             summary_frame;
  } cfg_t;

  // hex digit value; zero for anything that is not a hex digit
  function automatic logic [DIG_W-1:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
    end
    return d[DIG_W-1:0];
  endfunction

endpackage

### rtl/core/dlbd_expect.sv
// Expected block length: record_length * bytes_per_point * frames, registered
// from the next config value so it changes together with the config registers.
// Depends on dlbd_pkg.
module dlbd_expect (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dlbd_pkg::cfg_t             cfg,
  output logic [dlbd_pkg::EXP_W-1:0] exp_len
);

  logic [dlbd_pkg::RB_W-1:0]  rb;
  logic [dlbd_pkg::FC_W-1:0]  frames;
  logic [dlbd_pkg::EXP_W-1:0] exp_r;
  logic [dlbd_pkg::EXP_W-1:0] exp_nxt;

  // bytes_per_point is 2 bits: shift-add instead of a multiplier
  assign rb = (cfg.bytes_per_point[0] ? dlbd_pkg::RB_W'(cfg.record_length) : '0) +
              (cfg.bytes_per_point[1] ? {1'b0, cfg.record_length, 1'b0} : '0);

  assign frames = (cfg.fast_frame_enable && !cfg.summary_frame) ?
                  cfg.frame_count : dlbd_pkg::FC_W'(1);

  // 26 x 16 bit product
  assign exp_nxt = dlbd_pkg::EXP_W'(rb) * dlbd_pkg::EXP_W'(frames);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= dlbd_pkg::EXP_W'(1);
    end else begin
      exp_r <= exp_nxt;
    end
  end

  assign exp_len = exp_r;

endmodule

### rtl/core/dlbd_parse.sv
// Header parser and payload pass-through with the result register.
// Depends on dlbd_pkg.
module dlbd_parse #(
  parameter int unsigned MAX_LENGTH_DIGITS = dlbd_pkg::MAX_LEN_DIGITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_vld,
  input  dlbd_pkg::in_item_t         item,
  input  logic [dlbd_pkg::EXP_W-1:0] exp_len,
  output logic                       take,
  output logic                       out_vld,
  input  logic                       out_stall,
  output dlbd_pkg::out_item_t        out_data
);

  localparam int unsigned LW = dlbd_pkg::LEN_W;

  logic                       armed_r,  armed_nxt;
  logic [1:0]                 phase_r,  phase_nxt;
  logic [dlbd_pkg::DIG_W-1:0] digits_r, digits_nxt;
  logic [LW-1:0]              len_r,    len_nxt;
  logic [LW-1:0]              bytes_r,  bytes_nxt;
  logic                       bad_r,    bad_nxt;
  logic                       out_vld_r, out_vld_nxt;
  dlbd_pkg::out_item_t        out_item_r, out_item_nxt;

  logic                       has_result;
  logic                       out_free;
  logic [7:0]                 c;
  logic [dlbd_pkg::DIG_W-1:0] cnt;
  logic                       cnt_ok;
  logic                       is_dec;
  logic [LW-1:0]              len_mac;
  logic [LW-1:0]              len_upd;
  logic                       bad_upd;
  logic [dlbd_pkg::DIG_W-1:0] digits_dec;

  assign c          = item.stream_byte;
  assign has_result = (item.mode == dlbd_pkg::MODE_STREAM) && armed_r &&
                      (phase_r == dlbd_pkg::PH_PAYLOAD);
  assign out_free   = !out_vld_r || !out_stall;
  assign take       = item_vld && (out_free || !has_result);

  assign cnt     = dlbd_pkg::hex_value(c);
  assign cnt_ok  = (cnt != '0) && (cnt <= dlbd_pkg::DIG_W'(MAX_LENGTH_DIGITS));
  assign is_dec  = c inside {[8'h30:8'h39]};
  // len * 10 + digit, kept to LEN_W bits; low nibble of an ASCII digit is its value
  assign len_mac = {len_r[LW-4:0], 3'b000} + {len_r[LW-2:0], 1'b0} + LW'(c[3:0]);
  assign len_upd = is_dec ? len_mac : len_r;
  assign bad_upd = bad_r || !is_dec;
  assign digits_dec = (digits_r != '0) ? digits_r - 1'b1 : digits_r;

  always_comb begin
    armed_nxt    = armed_r;
    phase_nxt    = phase_r;
    digits_nxt   = digits_r;
    len_nxt      = len_r;
    bytes_nxt    = bytes_r;
    bad_nxt      = bad_r;
    out_vld_nxt  = out_vld_r && out_stall;
    out_item_nxt = out_item_r;
    if (take) begin
      case (item.mode)
        dlbd_pkg::MODE_ARM, dlbd_pkg::MODE_STOP: begin
          armed_nxt  = (item.mode == dlbd_pkg::MODE_ARM);
          phase_nxt  = dlbd_pkg::PH_HUNT;
          digits_nxt = '0;
          len_nxt    = '0;
          bytes_nxt  = '0;
          bad_nxt    = 1'b0;
        end
        dlbd_pkg::MODE_STREAM: begin
          if (armed_r) begin
            case (phase_r)
              dlbd_pkg::PH_HUNT: begin
                if (c == dlbd_pkg::CHAR_HASH) begin
                  phase_nxt = dlbd_pkg::PH_COUNT;
                end
              end
              dlbd_pkg::PH_COUNT: begin
                if (cnt_ok) begin
                  digits_nxt = cnt;
                  len_nxt    = '0;
                  bad_nxt    = 1'b0;
                  phase_nxt  = dlbd_pkg::PH_DIGITS;
                end else begin
                  phase_nxt  = dlbd_pkg::PH_HUNT;
                  digits_nxt = '0;
                  len_nxt    = '0;
                  bytes_nxt  = '0;
                  bad_nxt    = 1'b0;
                end
              end
              dlbd_pkg::PH_DIGITS: begin
                len_nxt    = len_upd;
                bad_nxt    = bad_upd;
                digits_nxt = digits_dec;
                if (digits_dec == '0) begin
                  if (!bad_upd && (len_upd != '0) && (len_upd == LW'(exp_len))) begin
                    bytes_nxt = len_upd;
                    phase_nxt = dlbd_pkg::PH_PAYLOAD;
                  end else begin
                    phase_nxt  = dlbd_pkg::PH_HUNT;
                    digits_nxt = '0;
                    len_nxt    = '0;
                    bytes_nxt  = '0;
                    bad_nxt    = 1'b0;
                  end
                end
              end
              default: begin
                out_vld_nxt               = 1'b1;
                out_item_nxt.payload_byte = c;
                if (bytes_r <= LW'(1)) begin
                  out_item_nxt.last_byte = 1'b1;
                  armed_nxt  = 1'b0;
                  phase_nxt  = dlbd_pkg::PH_HUNT;
                  digits_nxt = '0;
                  len_nxt    = '0;
                  bytes_nxt  = '0;
                  bad_nxt    = 1'b0;
                end else begin
                  out_item_nxt.last_byte = 1'b0;
                  bytes_nxt = bytes_r - 1'b1;
                end
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      phase_r   <= dlbd_pkg::PH_HUNT;
      digits_r  <= '0;
      len_r     <= '0;
      bytes_r   <= '0;
      bad_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      armed_r   <= armed_nxt;
      phase_r   <= phase_nxt;
      digits_r  <= digits_nxt;
      len_r     <= len_nxt;
      bytes_r   <= bytes_nxt;
      bad_r     <= bad_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_item_r;

endmodule

### rtl/core/definite_length_block_deframer_core.sv
// Definite-length block deframer: top level with config registers and input stage.
// Depends on dlbd_pkg, dlbd_expect and dlbd_parse.
//
// Byte-stream deframer for definite-length arbitrary blocks ("#", one hex count
// digit, that many decimal length digits, then the payload). An arm request
// (mode 1) starts hunting for '#', a stop request (mode 2) disarms; stream
// requests (mode 0) carry one byte each. The header is accepted only when the
// spelled length equals record_length * bytes_per_point * frames, frames being
// frame_count with fast-frame on and summary off, else 1. Bad headers are
// dropped and hunting resumes. Each payload byte comes out as one result; the
// final byte has last_byte set and disarms the block. Throughput is one request
// per clock while the result channel does not stall; a request passes the input
// register, the combinational parser and the result register. When the result
// channel stalls, a payload request waits in the input register and in_stall
// rises at once; other requests are still taken. The expected length is
// registered from the next config value, so it changes on the same edge as the
// config registers; the user must do config writes while idle (not enforced).
module definite_length_block_deframer_core #(
  parameter int unsigned MAX_LENGTH_DIGITS = dlbd_pkg::MAX_LEN_DIGITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_vld,
  output logic                            in_stall,
  input  dlbd_pkg::in_item_t              in_data,
  // result channel
  output logic                            out_vld,
  input  logic                            out_stall,
  output dlbd_pkg::out_item_t             out_data,
  // config write port
  input  logic                            cfg_we,
  input  logic [dlbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dlbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  dlbd_pkg::cfg_t     cfg_r, cfg_nxt;
  logic               in_vld_r, in_vld_nxt;
  dlbd_pkg::in_item_t in_item_r;
  logic               in_acc;
  logic               take;
  logic [dlbd_pkg::EXP_W-1:0] exp_len;

  // ---- config registers: values masked to their widths ----
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        dlbd_pkg::REG_RECORD_LENGTH: cfg_nxt.record_length =
                                       cfg_wdata[dlbd_pkg::RL_W-1:0];
        dlbd_pkg::REG_BYTES_PER_PT:  cfg_nxt.bytes_per_point =
                                       cfg_wdata[dlbd_pkg::BPP_W-1:0];
        dlbd_pkg::REG_FRAME_COUNT:   cfg_nxt.frame_count =
                                       cfg_wdata[dlbd_pkg::FC_W-1:0];
        dlbd_pkg::REG_FAST_FRAME:    cfg_nxt.fast_frame_enable = cfg_wdata[0];
        dlbd_pkg::REG_SUMMARY_FRAME: cfg_nxt.summary_frame = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.record_length     <= dlbd_pkg::RL_W'(1);
      cfg_r.bytes_per_point   <= dlbd_pkg::BPP_W'(1);
      cfg_r.frame_count       <= dlbd_pkg::FC_W'(1);
      cfg_r.fast_frame_enable <= 1'b0;
      cfg_r.summary_frame     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---- input register: refills in the same cycle the parser takes its request ----
  assign in_stall   = in_vld_r && !take;
  assign in_acc     = in_vld && !in_stall;
  assign in_vld_nxt = in_acc || (in_vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r <= in_data;
    end
  end

  // ---- expected length, tracks cfg_r edge for edge ----
  dlbd_expect u_expect (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_nxt),
    .exp_len (exp_len)
  );

  // ---- parser and result register ----
  dlbd_parse #(
    .MAX_LENGTH_DIGITS (MAX_LENGTH_DIGITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (in_vld_r),
    .item      (in_item_r),
    .exp_len   (exp_len),
    .take      (take),
    .out_vld   (out_vld),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/core/dlbd_checker.sv
// Port-level checks for the deframer core, attached by bind.
// Depends on dlbd_pkg and definite_length_block_deframer_core.
module dlbd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_vld,
  input logic                in_stall,
  input dlbd_pkg::in_item_t  in_data,
  input logic                out_vld,
  input logic                out_stall,
  input dlbd_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_stall |=> out_vld && $stable(out_data))
    else $error("stalled result dropped or changed");

  // a fresh result follows an accepted request through the input and result registers
  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld) |-> $past(in_vld && !in_stall, 2))
    else $error("result without a request");

  // arm, stop and unused requests never produce a result
  a_ctrl_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld && !in_stall && (in_data.mode != dlbd_pkg::MODE_STREAM)
      |-> ##2 !$rose(out_vld))
    else $error("control request produced a result");

endmodule

bind definite_length_block_deframer_core dlbd_checker u_dlbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_vld    (in_vld),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_vld   (out_vld),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/dlbd_payload_checker.sv
// Payload checker for the definite-length block deframer core: follows the
// request, result and register write ports, predicts each payload byte and compares.
// Depends on dlbd_pkg only.
module dlbd_payload_checker
  import dlbd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_vld,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           bytes_waiting,
  output int unsigned           bytes_checked,
  output int unsigned           blocks_closed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  cfg_t             regs;
  logic             armed;
  logic [1:0]       phase;
  logic [DIG_W-1:0] digits_left;
  logic [LEN_W-1:0] length_acc;
  logic [LEN_W-1:0] bytes_left;
  logic             length_bad;
  out_item_t        expected_payload[$];

  function automatic void clear_parser();
    phase       = PH_HUNT;
    digits_left = '0;
    length_acc  = '0;
    bytes_left  = '0;
    length_bad  = 1'b0;
  endfunction

  // value of a hex character, zero when it is none
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
    return 0;
  endfunction

  function automatic logic [63:0] header_length();
    logic [63:0] frames;
    frames = (regs.fast_frame_enable && !regs.summary_frame) ? 64'(regs.frame_count) : 64'd1;
    return 64'(regs.record_length) * 64'(regs.bytes_per_point) * frames;
  endfunction

  function automatic void advance_parser(input in_item_t r);
    int        nib;
    out_item_t res;
    case (r.mode)
      MODE_ARM: begin
        armed = 1'b1;
        clear_parser();
      end
      MODE_STOP: begin
        armed = 1'b0;
        clear_parser();
      end
      MODE_STREAM: begin
        if (armed) begin
          case (phase)
            PH_HUNT: begin
              if (r.stream_byte == CHAR_HASH) phase = PH_COUNT;
            end
            PH_COUNT: begin
              nib = nibble_of(r.stream_byte);
              if (nib >= 1 && nib <= MAX_LEN_DIGITS) begin
                digits_left = DIG_W'(nib);
                length_acc  = '0;
                length_bad  = 1'b0;
                phase       = PH_DIGITS;
              end else begin
                clear_parser();
              end
            end
            PH_DIGITS: begin
              if (r.stream_byte >= CH_ZERO && r.stream_byte <= CH_NINE) begin
                length_acc = LEN_W'(64'(length_acc) * 64'd10 + 64'(r.stream_byte - CH_ZERO));
              end else begin
                length_bad = 1'b1;
              end
              if (digits_left != 0) digits_left = digits_left - 1'b1;
              if (digits_left == 0) begin
                if (!length_bad && length_acc != 0 && 64'(length_acc) == header_length()) begin
                  bytes_left = length_acc;
                  phase      = PH_PAYLOAD;
                end else begin
                  clear_parser();
                end
              end
            end
            default: begin
              res.payload_byte = r.stream_byte;
              res.last_byte    = (bytes_left <= 1);
              expected_payload.push_back(res);
              if (res.last_byte) begin
                armed = 1'b0;
                clear_parser();
              end else begin
                bytes_left = bytes_left - 1'b1;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      regs = '{record_length: RL_W'(1), bytes_per_point: BPP_W'(1), frame_count: FC_W'(1),
               fast_frame_enable: 1'b0, summary_frame: 1'b0};
      armed = 1'b0;
      clear_parser();
      expected_payload.delete();
      mismatches    = 0;
      bytes_checked = 0;
      blocks_closed = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_RECORD_LENGTH: regs.record_length     = cfg_wdata[RL_W-1:0];
          REG_BYTES_PER_PT:  regs.bytes_per_point   = cfg_wdata[BPP_W-1:0];
          REG_FRAME_COUNT:   regs.frame_count       = cfg_wdata[FC_W-1:0];
          REG_FAST_FRAME:    regs.fast_frame_enable = cfg_wdata[0];
          REG_SUMMARY_FRAME: regs.summary_frame     = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_vld && !in_stall) advance_parser(in_data);
      if (out_vld && !out_stall) begin
        if (expected_payload.size() == 0) begin
          $error("unexpected result: payload_byte %02h last_byte %0b",
                 out_data.payload_byte, out_data.last_byte);
          mismatches++;
        end else begin
          want = expected_payload.pop_front();
          if (out_data.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %02h, actual %02h",
                   want.payload_byte, out_data.payload_byte);
            mismatches++;
          end
          if (out_data.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, actual %0b", want.last_byte, out_data.last_byte);
            mismatches++;
          end
          bytes_checked++;
          if (want.last_byte) blocks_closed++;
        end
      end
    end
    bytes_waiting = expected_payload.size();
  end

endmodule

### tb/tb_definite_length_block_deframer_core.sv
// Top of the block deframer testbench: clock, reset, request stimulus,
// register settings and verdict. Depends on dlbd_pkg, dlbd_payload_checker and the core.
module tb_definite_length_block_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import dlbd_pkg::*;

  // mode value the block must ignore
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  localparam int unsigned PHASE_ITEMS   = 140;    // random requests per register setting
  localparam int unsigned SETTLE_CYCLES = 8;      // input and result registers plus margin
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned TRUNC_LEN     = 48;     // longer blocks are always cut short

  localparam cfg_t RESET_CFG = '{record_length: RL_W'(1), bytes_per_point: BPP_W'(1),
                                 frame_count: FC_W'(1), fast_frame_enable: 1'b0,
                                 summary_frame: 1'b0};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_vld    = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_vld;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned bytes_waiting;
  int unsigned bytes_checked;
  int unsigned blocks_closed;

  int unsigned cycle_count   = 0;
  int unsigned requests_sent = 0;
  int unsigned settings_done = 0;
  bit          quiet_run     = 1'b0;   // no idling on either side while set
  cfg_t        cur_cfg       = RESET_CFG;

  definite_length_block_deframer_core DUT (.*);

  dlbd_payload_checker payload_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop: a hung handshake or a lost payload byte ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("tb_definite_length_block_deframer_core failed");
      $finish;
    end
  end

  // result side back-pressure, raised at random with a chance of 8 in 100
  always @(posedge clk) begin
    out_stall <= !quiet_run && ($urandom_range(0, 99) < 8);
  end

  // One request: optional idle gap, then hold valid and payload until taken.
  // Valid is only dropped in the gap, so it never falls and rises in one step.
  // Idle gaps come before 3 requests in 100.
  task automatic send_req(input logic [1:0] req_mode, input logic [7:0] c,
                          input bit counted = 1'b1);
    if (!quiet_run && $urandom_range(0, 99) < 3) begin
      in_vld <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_vld  <= 1'b1;
    in_data <= in_item_t'{mode: req_mode, stream_byte: c};
    do @(posedge clk); while (in_stall);
    if (counted) requests_sent++;
  endtask

  // Wait for every predicted payload byte, then let requests that cause no
  // result drain through the pipe before registers may change.
  task automatic settle();
    in_vld <= 1'b0;
    do @(posedge clk); while (bytes_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All five registers, back to back. Narrow registers get junk above their
  // width, which the block has to mask off.
  task automatic write_config(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_RECORD_LENGTH;
    cfg_wdata <= CFG_DATA_W'(c.record_length);
    @(posedge clk);
    cfg_idx   <= REG_BYTES_PER_PT;
    cfg_wdata <= CFG_DATA_W'({$urandom, c.bytes_per_point});
    @(posedge clk);
    cfg_idx   <= REG_FRAME_COUNT;
    cfg_wdata <= CFG_DATA_W'({$urandom, c.frame_count});
    @(posedge clk);
    cfg_idx   <= REG_FAST_FRAME;
    cfg_wdata <= CFG_DATA_W'({$urandom, c.fast_frame_enable});
    @(posedge clk);
    cfg_idx   <= REG_SUMMARY_FRAME;
    cfg_wdata <= CFG_DATA_W'({$urandom, c.summary_frame});
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cfg = c;
    settings_done++;
  endtask

  // payload length the current setting asks for
  function automatic longint unsigned block_len();
    logic [63:0] frames;
    frames = (cur_cfg.fast_frame_enable && !cur_cfg.summary_frame) ?
             64'(cur_cfg.frame_count) : 64'd1;
    return 64'(cur_cfg.record_length) * 64'(cur_cfg.bytes_per_point) * frames;
  endfunction

  function automatic int dec_digits(input longint unsigned v);
    int nd;
    nd = 1;
    while (v >= 10) begin
      v = v / 10;
      nd++;
    end
    return nd;
  endfunction

  // digit-count character, either case for 10..15
  function automatic logic [7:0] count_char(input int n);
    if (n < 10) return 8'(CH_ZERO + n);
    if ($urandom_range(0, 1)) return 8'(CH_UPPER_A + n - 10);
    return 8'(CH_LOWER_A + n - 10);
  endfunction

  // '#', count digit, ndig decimal digits of len (leading zeros as needed);
  // the digit at bad_pos, counted from the low end, is replaced by a non-digit
  task automatic send_header(input longint unsigned len, input int ndig, input int bad_pos);
    byte unsigned    digs[MAX_LEN_DIGITS];
    longint unsigned rest;
    logic [7:0]      c;
    rest = len;
    for (int i = 0; i < MAX_LEN_DIGITS; i++) begin
      digs[i] = 8'(rest % 10);
      rest = rest / 10;
    end
    send_req(MODE_STREAM, CHAR_HASH);
    send_req(MODE_STREAM, count_char(ndig));
    for (int k = ndig - 1; k >= 0; k--) begin
      c = 8'(CH_ZERO + digs[k]);
      if (k == bad_pos) begin
        do c = 8'($urandom); while (c >= CH_ZERO && c <= CH_NINE);
      end
      send_req(MODE_STREAM, c);
    end
  endtask

  // random payload, with a stray '#' now and then that must pass as data
  task automatic send_payload(input longint unsigned n);
    logic [7:0] c;
    for (longint unsigned i = 0; i < n; i++) begin
      c = ($urandom_range(0, 15) == 0) ? CHAR_HASH : 8'($urandom);
      send_req(MODE_STREAM, c);
    end
  endtask

  // Well-formed block for the current setting. Huge blocks (and a few short
  // ones) are cut off by a stop or a re-arm partway through the payload.
  task automatic send_block(input bit do_arm);
    longint unsigned len;
    int              nd;
    int              ndig;
    longint unsigned cut;
    logic [7:0]      c;
    len  = block_len();
    nd   = dec_digits(len);
    ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(nd, MAX_LEN_DIGITS) : nd;
    if (do_arm) send_req(MODE_ARM, 8'($urandom));
    repeat ($urandom_range(0, 2)) begin
      c = 8'($urandom);
      if (c == CHAR_HASH) c = CH_ZERO;
      send_req(MODE_STREAM, c);
    end
    send_header(len, ndig, -1);
    if (len == 0) return;   // zero length: header dropped, still hunting
    if (len > TRUNC_LEN || $urandom_range(0, 9) == 0) begin
      cut = 64'((len > TRUNC_LEN) ? $urandom_range(0, 20) : $urandom_range(0, int'(len) - 1));
      send_payload(cut);
      send_req($urandom_range(0, 1) ? MODE_ARM : MODE_STOP, 8'($urandom));
    end else begin
      send_payload(len);
    end
  endtask

  // Broken sequences; half of them are followed by a good block, which the
  // parser must still find once it is back to hunting.
  task automatic send_broken();
    longint unsigned len;
    longint unsigned wrong;
    logic [7:0]      c;
    int              ndig;
    int              sel;
    len = block_len();
    sel = $urandom_range(0, 4);
    send_req(MODE_ARM, 8'($urandom));
    case (sel)
      0: begin
        // count digit that is not 1..F
        send_req(MODE_STREAM, CHAR_HASH);
        if ($urandom_range(0, 3) == 0) begin
          c = CH_ZERO;
        end else begin
          do c = 8'($urandom);
          while ((c > CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_F) ||
                 (c >= CH_LOWER_A && c <= CH_LOWER_F));
        end
        send_req(MODE_STREAM, c);
      end
      1: begin
        // one length digit not decimal
        ndig = $urandom_range(1, MAX_LEN_DIGITS);
        send_header(len, ndig, $urandom_range(0, ndig - 1));
      end
      2: begin
        // length off by a little, or zero
        if ($urandom_range(0, 1)) begin
          wrong = len + 64'($urandom_range(1, 9));
        end else begin
          wrong = (len > 0) ? len - 1 : 64'd0;
        end
        send_header(wrong, dec_digits(wrong), -1);
      end
      3: begin
        // header cut short by a stop or a re-arm
        send_req(MODE_STREAM, CHAR_HASH);
        if ($urandom_range(0, 1)) begin
          ndig = $urandom_range(2, MAX_LEN_DIGITS);
          send_req(MODE_STREAM, count_char(ndig));
          repeat ($urandom_range(0, ndig - 1)) begin
            send_req(MODE_STREAM, 8'(CH_ZERO + $urandom_range(0, 9)));
          end
        end
        send_req($urandom_range(0, 1) ? MODE_ARM : MODE_STOP, 8'($urandom));
      end
      default: begin
        // unused mode, then bytes while disarmed, which the block ignores
        send_req(MODE_UNUSED, 8'($urandom));
        send_req(MODE_STOP, 8'($urandom));
        repeat ($urandom_range(1, 3)) send_req(MODE_STREAM, 8'($urandom), 1'b0);
      end
    endcase
    if ($urandom_range(0, 1)) send_block(sel >= 3);
  endtask

  task automatic run_phase(input cfg_t c);
    int unsigned goal;
    write_config(c);
    goal = requests_sent + PHASE_ITEMS;
    while (requests_sent < goal) begin
      if ($urandom_range(0, 99) < 70) begin
        send_block(1'b1);
      end else begin
        send_broken();
      end
      if ($urandom_range(0, 9) == 0) send_req(MODE_STREAM, 8'($urandom), 1'b0);
    end
    settle();
  endtask

  initial begin
    cfg_t c;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings (expected length 1)
    send_req(MODE_STREAM, CHAR_HASH);        // not armed: ignored
    send_req(MODE_UNUSED, 8'hFF);            // unused mode: no effect
    send_req(MODE_ARM, 8'h00);
    send_req(MODE_STREAM, CHAR_HASH);
    send_req(MODE_STREAM, CH_ZERO);          // count digit zero: back to hunting
    send_header(1, 1, 0);                    // non-decimal length digit
    send_header(1, MAX_LEN_DIGITS, -1);      // widest header, leading zeros
    send_req(MODE_STREAM, 8'hFF);            // only byte, flagged last, disarms
    send_req(MODE_STOP, 8'h00);
    settle();

    run_phase(RESET_CFG);

    // long stretch with no idling on either side
    quiet_run = 1'b1;
    run_phase('{record_length: 24'd5, bytes_per_point: 2'd2, frame_count: 16'd3,
                fast_frame_enable: 1'b1, summary_frame: 1'b0});
    quiet_run = 1'b0;

    // summary frame overrides the frame count
    run_phase('{record_length: 24'd7, bytes_per_point: 2'd1, frame_count: 16'd4,
                fast_frame_enable: 1'b1, summary_frame: 1'b1});
    // top of the record_length and frame_count ranges: 13-digit length, payload always cut short
    run_phase('{record_length: 24'hFFFFFF, bytes_per_point: 2'd2, frame_count: 16'hFFFF,
                fast_frame_enable: 1'b1, summary_frame: 1'b0});
    // bytes_per_point 3 is taken as written
    run_phase('{record_length: 24'd3, bytes_per_point: 2'd3, frame_count: 16'hFFFF,
                fast_frame_enable: 1'b0, summary_frame: 1'b1});
    // zero expected length: every header is rejected
    run_phase('{record_length: 24'd1, bytes_per_point: 2'd0, frame_count: 16'd0,
                fast_frame_enable: 1'b1, summary_frame: 1'b0});
    run_phase('{record_length: 24'hFFFFFF, bytes_per_point: 2'd1, frame_count: 16'd2,
                fast_frame_enable: 1'b0, summary_frame: 1'b0});

    for (int p = 0; p < 4; p++) begin
      c.record_length     = RL_W'($urandom_range(1, 12));
      c.bytes_per_point   = BPP_W'($urandom_range(1, 2));
      c.frame_count       = FC_W'($urandom_range(1, 6));
      c.fast_frame_enable = 1'($urandom);
      c.summary_frame     = 1'($urandom);
      run_phase(c);
    end

    $display("Sent %0d requests across %0d register settings;", requests_sent, settings_done);
    $display("%0d payload bytes and %0d blocks checked.", bytes_checked, blocks_closed);
    if (mismatches == 0) begin
      $display("tb_definite_length_block_deframer_core passed");
    end else begin
      $display("tb_definite_length_block_deframer_core failed");
    end
    $finish;
  end

endmodule
